@@ src/checked_integer_power_assert.svh @@
// Assertion macros for the checker of this block.
`ifndef CHECKED_INTEGER_POWER_ASSERT_SVH
`define CHECKED_INTEGER_POWER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CKPOW_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("checked_integer_power: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define CKPOW_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("checked_integer_power: next-cycle check failed");

`endif

@@ src/ckpow_pkg.sv @@
package ckpow_pkg;

  localparam int Width = 32;
  localparam int ExpW  = $clog2(Width);

  localparam logic [Width-1:0] SignBit   = {1'b1, {(Width-1){1'b0}}};
  localparam logic [Width-1:0] MagMaxPos = SignBit - 1'b1;
  localparam logic [Width-1:0] MagMaxNeg = SignBit;
  localparam logic [Width-1:0] PowerOne  = {{(Width-1){1'b0}}, 1'b1};
  localparam logic [Width-1:0] PowerZero = '0;
  localparam logic [Width-1:0] PowerNegOne = '1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NEGEXP   = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_MCHK,
    S_SQR,
    S_SCHK
  } state_t;

  typedef struct packed {
    logic signed [Width-1:0] base;
    logic signed [Width-1:0] exponent;
  } operands_t;

  typedef struct packed {
    logic signed [Width-1:0] power;
    status_t                 status;
  } result_t;

endpackage

@@ src/checked_integer_power.sv @@
// Checked integer power. A beat is taken at a rising edge where start is high
// and busy is low; it carries a signed 32-bit base and a signed 32-bit exponent.
// The result beat (power and status) is shown for exactly one cycle with done
// high, and the receiver cannot hold it off. A negative exponent, a zero
// exponent, a base of 0, 1 or -1, and an exponent of 32 or more with a larger
// base are settled at once: done rises in the cycle right after the start beat.
// Every other beat runs exponentiation by squaring over the low five exponent
// bits on one shared 32x32 multiplier whose product is registered; each
// multiply (a square, or the running result times the current square) runs
// through a multiply state and then a check state of the product. busy is low
// again in the cycle that done is high, so a new start beat can be taken there.
// Status is 0 for ok, 1 for a negative exponent and 2 when the exact power
// leaves the signed 32-bit range; power is zero whenever status is not ok.
// A square that exceeds the range only counts as overflow when a higher
// exponent bit is still set, so unused squares never raise a false overflow.
module checked_integer_power (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  ckpow_pkg::operands_t  operands,
  output logic                  busy,
  output logic                  done,
  output ckpow_pkg::result_t    result
);

  localparam int W = ckpow_pkg::Width;
  localparam int E = ckpow_pkg::ExpW;

  ckpow_pkg::state_t  state, state_next;
  ckpow_pkg::result_t result_next;
  logic               done_next;

  // Magnitudes: r is the running result, s the current square of the base.
  logic [W-1:0]   r, r_next, s, s_next;
  logic [2*W-1:0] prod, prod_next;
  logic [E-1:0]   e_rem, e_rem_next;
  logic           rneg, rneg_next;

  logic [W-1:0]   bmag, limit, mul_a, mul_b, mag_signed;
  logic           bneg, e_neg, e_zero, e_big, b_small, special;
  logic           prod_ovf, e_last;

  // Input classification, used only when a start beat is taken.
  assign bneg    = operands.base[W-1];
  assign bmag    = bneg ? (~$unsigned(operands.base) + 1'b1) : $unsigned(operands.base);
  assign e_neg   = operands.exponent[W-1];
  assign e_zero  = (operands.exponent == '0);
  // With a base magnitude of two or more, any exponent of W or above overflows.
  assign e_big   = (operands.exponent[W-2:E] != '0);
  assign b_small = (bmag[W-1:1] == '0);
  assign special = e_neg | e_zero | b_small | e_big;

  // A negative result may reach the most negative value.
  assign limit    = rneg ? ckpow_pkg::MagMaxNeg : ckpow_pkg::MagMaxPos;
  assign prod_ovf = (prod > {{W{1'b0}}, limit});
  assign e_last   = (e_rem[E-1:1] == '0);

  // Final value from the low half of the checked product.
  assign mag_signed = rneg ? (~prod[W-1:0] + 1'b1) : prod[W-1:0];

  // The shared multiplier: running result times square, or square times square.
  assign mul_a     = (state == ckpow_pkg::S_MUL) ? r : s;
  assign mul_b     = s;
  assign prod_next = {{W{1'b0}}, mul_a} * {{W{1'b0}}, mul_b};

  assign busy = (state != ckpow_pkg::S_IDLE);

  // Next-state logic of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      ckpow_pkg::S_IDLE: begin
        if (start && !special) begin
          state_next = operands.exponent[0] ? ckpow_pkg::S_MUL : ckpow_pkg::S_SQR;
        end
      end
      ckpow_pkg::S_MUL: begin
        state_next = ckpow_pkg::S_MCHK;
      end
      ckpow_pkg::S_MCHK: begin
        if (prod_ovf || e_last) begin
          state_next = ckpow_pkg::S_IDLE;
        end else begin
          state_next = ckpow_pkg::S_SQR;
        end
      end
      ckpow_pkg::S_SQR: begin
        state_next = ckpow_pkg::S_SCHK;
      end
      ckpow_pkg::S_SCHK: begin
        if (prod_ovf) begin
          state_next = ckpow_pkg::S_IDLE;
        end else begin
          state_next = e_rem[1] ? ckpow_pkg::S_MUL : ckpow_pkg::S_SQR;
        end
      end
      default: begin
        state_next = ckpow_pkg::S_IDLE;
      end
    endcase
  end

  // Datapath and result registers.
  always_comb begin
    r_next      = r;
    s_next      = s;
    e_rem_next  = e_rem;
    rneg_next   = rneg;
    result_next = result;
    done_next   = 1'b0;
    case (state)
      ckpow_pkg::S_IDLE: begin
        if (start) begin
          r_next     = ckpow_pkg::PowerOne;
          s_next     = bmag;
          e_rem_next = operands.exponent[E-1:0];
          rneg_next  = bneg & operands.exponent[0];
          if (special) begin
            done_next          = 1'b1;
            result_next.status = ckpow_pkg::ST_OK;
            if (e_neg) begin
              result_next.power  = ckpow_pkg::PowerZero;
              result_next.status = ckpow_pkg::ST_NEGEXP;
            end else if (e_zero) begin
              result_next.power = ckpow_pkg::PowerOne;
            end else if (b_small) begin
              if (bmag[0] == 1'b0) begin
                result_next.power = ckpow_pkg::PowerZero;
              end else if (bneg && operands.exponent[0]) begin
                result_next.power = ckpow_pkg::PowerNegOne;
              end else begin
                result_next.power = ckpow_pkg::PowerOne;
              end
            end else begin
              result_next.power  = ckpow_pkg::PowerZero;
              result_next.status = ckpow_pkg::ST_OVERFLOW;
            end
          end
        end
      end
      ckpow_pkg::S_MCHK: begin
        if (prod_ovf) begin
          done_next          = 1'b1;
          result_next.power  = ckpow_pkg::PowerZero;
          result_next.status = ckpow_pkg::ST_OVERFLOW;
        end else begin
          r_next = prod[W-1:0];
          if (e_last) begin
            done_next          = 1'b1;
            result_next.power  = mag_signed;
            result_next.status = ckpow_pkg::ST_OK;
          end
        end
      end
      ckpow_pkg::S_SCHK: begin
        // A higher exponent bit is still set here, so a square past the
        // limit means the final power is past it too.
        if (prod_ovf) begin
          done_next          = 1'b1;
          result_next.power  = ckpow_pkg::PowerZero;
          result_next.status = ckpow_pkg::ST_OVERFLOW;
        end else begin
          s_next     = prod[W-1:0];
          e_rem_next = e_rem >> 1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ckpow_pkg::S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    r      <= r_next;
    s      <= s_next;
    e_rem  <= e_rem_next;
    rneg   <= rneg_next;
    prod   <= prod_next;
    result <= result_next;
  end

endmodule

@@ src/ckpow_checker.sv @@
`include "checked_integer_power_assert.svh"

module ckpow_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 start,
  input ckpow_pkg::operands_t operands,
  input logic                 busy,
  input logic                 done,
  input ckpow_pkg::result_t   result
);

  logic take;
  assign take = start && !busy;

  // A failed beat never carries a power.
  `CKPOW_ASSERT_SAME(a_fail_zero, clk, rst, done && (result.status != ckpow_pkg::ST_OK), result.power == ckpow_pkg::PowerZero)

  // The block is free again in the cycle that shows a result.
  `CKPOW_ASSERT_SAME(a_done_idle, clk, rst, done, !busy)

  // A negative exponent is answered in the very next cycle.
  `CKPOW_ASSERT_NEXT(a_negexp, clk, rst, take && operands.exponent[ckpow_pkg::Width-1], done && (result.status == ckpow_pkg::ST_NEGEXP))

  // A zero exponent yields one in the very next cycle.
  `CKPOW_ASSERT_NEXT(a_zeroexp, clk, rst, take && (operands.exponent == '0), done && (result.power == ckpow_pkg::PowerOne) && (result.status == ckpow_pkg::ST_OK))

  // A taken beat either answers at once or keeps the block busy.
  `CKPOW_ASSERT_NEXT(a_progress, clk, rst, take, busy || done)

endmodule

bind checked_integer_power ckpow_checker u_ckpow_checker (.*);
